// File: design/scpd_pkg.sv
// ----------------------------------------------------------------------------
// scpd_pkg: shared types and constants
// Stack sizing, field widths, status codes, FSM states and the
// control/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package scpd_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int AW          = $clog2(STACK_DEPTH);
	localparam int CNT_W       = AW + 1;
	localparam int HASH_W      = 64;
	localparam int IDX_W       = 10;
	localparam int STAT_W      = 2;

	localparam logic [IDX_W-1:0] MAX_STEPS_RST = IDX_W'(999);
	localparam logic [IDX_W-1:0] STEP_FIRST    = IDX_W'(1);

	typedef enum logic [STAT_W-1:0] {
		ST_SEARCH  = 2'd0,
		ST_FOUND   = 2'd1,
		ST_GAVEUP  = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_CMP  = 1'b1
	} state_t;

	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic [IDX_W-1:0]  idx;
	} entry_t;

	typedef struct packed {
		logic accept;   // latch new item
		logic pop;      // drop top entry
		logic resolve;  // match / push, write result
		logic ignore;   // write "ignored" result
	} cmd_t;

	typedef struct packed {
		logic finished;
		logic empty;
		logic top_gt;
		logic out_free;
	} sts_t;

endpackage

// File: design/scpd_stack_mem.sv
// ----------------------------------------------------------------------------
// scpd_stack_mem: stack storage
// One write port, one read port with registered read data. Contents are
// not reset; only entries below the stack count are ever read.
// ----------------------------------------------------------------------------
module scpd_stack_mem (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [scpd_pkg::AW-1:0] wr_addr,
	input  scpd_pkg::entry_t     wr_data,
	input  logic                 rd_en,
	input  logic [scpd_pkg::AW-1:0] rd_addr,
	output scpd_pkg::entry_t     rd_data
);
	import scpd_pkg::*;

	entry_t mem_q [STACK_DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: design/scpd_ctrl.sv
// ----------------------------------------------------------------------------
// scpd_ctrl: sequencing FSM
// Takes an item in IDLE, then loops in CMP popping larger entries until
// the item can be resolved, or ignored after a finish, and the output register is free.
// ----------------------------------------------------------------------------
module scpd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  scpd_pkg::sts_t sts,
	output scpd_pkg::cmd_t cmd
);
	import scpd_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_CMP;
			end
			S_CMP: begin
				priority if (sts.finished) begin
					if (sts.out_free) state_nxt = S_IDLE;
				end else if (!sts.empty && sts.top_gt) begin
					state_nxt = S_CMP;
				end else if (sts.out_free) begin
					state_nxt = S_IDLE;
				end else begin
					state_nxt = S_CMP;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			S_CMP: begin
				priority if (sts.finished) begin
					cmd.ignore = sts.out_free;
				end else if (!sts.empty && sts.top_gt) begin
					cmd.pop = 1'b1;
				end else begin
					cmd.resolve = sts.out_free;
				end
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// File: design/scpd_datapath.sv
// ----------------------------------------------------------------------------
// scpd_datapath: stack pointer, top-of-stack cache, step counter, result
// Keeps a register copy of the top entry; after a pop the new top comes
// from the stack RAM read data and is folded back into the cache.
// ----------------------------------------------------------------------------
module scpd_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  scpd_pkg::cmd_t              cmd,
	output scpd_pkg::sts_t              sts,
	input  logic [scpd_pkg::HASH_W-1:0] hash_value,
	input  logic                        start_req,
	input  logic                        cfg_we,
	input  logic [scpd_pkg::IDX_W-1:0]  cfg_wdata,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [scpd_pkg::STAT_W-1:0] status,
	output logic [scpd_pkg::IDX_W-1:0]  period
);
	import scpd_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

	logic [HASH_W-1:0] hash_q;
	logic [IDX_W-1:0]  step_q;
	logic [IDX_W-1:0]  max_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              fin_q;
	logic              use_rd_q;
	entry_t            top_q;
	logic              out_valid_q;
	status_t           status_q;
	logic [IDX_W-1:0]  period_q;

	entry_t            top;
	entry_t            rd_data;
	entry_t            wr_data;
	logic              rd_en;
	logic              wr_en;
	logic              empty;
	logic              match;
	logic              give_up;
	logic              out_free;

	// top entry: RAM read data right after a pop, else the cache
	assign top      = use_rd_q ? rd_data : top_q;
	assign empty    = (cnt_q == '0);
	assign match    = !empty && (top.hash == hash_q);
	assign give_up  = (step_q >= max_q);
	assign out_free = !out_valid_q || !out_stall;

	assign rd_en   = cmd.pop && (cnt_q >= CNT_W'(2));
	assign wr_en   = cmd.resolve && !match && (cnt_q < DEPTH_C);
	assign wr_data = '{hash: hash_q, idx: step_q};

	assign sts.finished = fin_q;
	assign sts.empty    = empty;
	assign sts.top_gt   = top.hash > hash_q;
	assign sts.out_free = out_free;

	scpd_stack_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (AW'(cnt_q - CNT_W'(2))),
		.rd_data (rd_data)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			step_q      <= STEP_FIRST;
			fin_q       <= 1'b0;
			max_q       <= MAX_STEPS_RST;
			use_rd_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			use_rd_q <= rd_en;
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (cmd.accept && start_req) begin
				cnt_q  <= '0;
				step_q <= STEP_FIRST;
				fin_q  <= 1'b0;
			end
			if (cmd.pop) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.resolve) begin
				if (match) begin
					fin_q <= 1'b1;
				end else begin
					if (wr_en) cnt_q <= cnt_q + CNT_W'(1);
					if (give_up) begin
						fin_q <= 1'b1;
					end else begin
						step_q <= step_q + IDX_W'(1);
					end
				end
			end
			if (cmd.resolve || cmd.ignore) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			hash_q <= hash_value;
		end
		if (wr_en) begin
			top_q <= wr_data;
		end else if (use_rd_q) begin
			top_q <= rd_data;
		end
		if (cmd.ignore) begin
			status_q <= ST_IGNORED;
			period_q <= '0;
		end else if (cmd.resolve) begin
			priority if (match) begin
				status_q <= ST_FOUND;
				period_q <= step_q - top.idx;
			end else if (give_up) begin
				status_q <= ST_GAVEUP;
				period_q <= '0;
			end else begin
				status_q <= ST_SEARCH;
				period_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign period    = period_q;

	// a result is never written over one that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.resolve || cmd.ignore) |-> out_free)
		else $error("result register overwritten while stalled");

	// stack count stays within the RAM
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("stack count beyond depth");

	// a found period ends the search
	a_found_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.resolve && match) |=> (fin_q && status_q == ST_FOUND))
		else $error("match did not finish the search");

	// a pop never happens on an empty stack
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !empty)
		else $error("pop on empty stack");

endmodule

// File: design/stack_cycle_period_detector_unit.sv
// Timing: after the input transfer the controller enters CMP, pops every
//   larger entry, then resolves and registers the result once the output
//   register is free. The input stalls until then; the pop loop reads one
//   entry per cycle from the single stack RAM read port.
// Reset: stack empty, step index 1, max_steps 999, no result pending. Stack
//   RAM contents are not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
// stack_cycle_period_detector_unit: monotonic-stack period detector
// Takes one 64-bit hash per generation, keeps a stack of (hash, index) with
// strictly increasing hashes, and reports the period on the first repeat.
// ----------------------------------------------------------------------------
module stack_cycle_period_detector_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration: max_steps
	input  logic                        cfg_we,
	input  logic [scpd_pkg::IDX_W-1:0]  cfg_wdata,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [scpd_pkg::HASH_W-1:0] hash_value,
	input  logic                        start_req,
	// output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [scpd_pkg::STAT_W-1:0] status,
	output logic [scpd_pkg::IDX_W-1:0]  period
);
	import scpd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Controller: IDLE takes one transfer; CMP pops entries with a larger
	// hash one per cycle, then resolves (match, push, give-up), or after a
	// finish ignores the item, once the output register can take the result.
	scpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: stack RAM with top-of-stack cache, step counter, the
	// max_steps register and the output register that decouples the
	// result from the next input transfer.
	scpd_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.hash_value (hash_value),
		.start_req  (start_req),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.period     (period)
	);

endmodule

// File: tb/stack_cycle_period_detector_unit_tb.sv
// ----------------------------------------------------------------------------
// stack_cycle_period_detector_unit_tb: period detector testbench
// Drives hash sequences through the detector and checks every status/period
// result against a behavioral copy of the monotonic-stack search. A short
// directed part covers the first repeat, restart, the step limit at zero, one
// and two, and the ignored-after-finish case. Random periodic runs with random
// content, restarts cut into them, collision-heavy noise and step limit
// changes follow. Sender gaps and receiver stalls come in random bursts.
// ----------------------------------------------------------------------------
module stack_cycle_period_detector_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import scpd_pkg::*;

	// no transfer on either side for this many cycles ends the run; the
	// slowest legal item pops at most a full stack plus one receiver stall burst
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS   = 420;

	typedef struct packed {
		status_t          stat;
		logic [IDX_W-1:0] per;
	} report_t;

	// ------------------------------------------------------------------------
	// clock, reset and block ports; every input known from time zero
	// ------------------------------------------------------------------------
	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              cfg_we     = 1'b0;
	logic [IDX_W-1:0]  cfg_wdata  = '0;
	logic              in_valid   = 1'b0;
	logic              in_stall;
	logic [HASH_W-1:0] hash_value = '0;
	logic              start_req  = 1'b0;
	logic              out_valid;
	logic              out_stall  = 1'b0;
	logic [STAT_W-1:0] status;
	logic [IDX_W-1:0]  period;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	stack_cycle_period_detector_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.hash_value (hash_value),
		.start_req  (start_req),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.period     (period)
	);

	// ------------------------------------------------------------------------
	// shadow of the detector state
	// stack entries below stk_depth are the only ones ever read
	// ------------------------------------------------------------------------
	logic [HASH_W-1:0] stk_hash [STACK_DEPTH];
	logic [IDX_W-1:0]  stk_idx  [STACK_DEPTH];
	int                stk_depth  = 0;
	logic [IDX_W-1:0]  step_no    = STEP_FIRST;
	bit                run_done   = 1'b0;
	logic [IDX_W-1:0]  step_limit = MAX_STEPS_RST;

	report_t period_reports [$];   // expected results, oldest first
	int      errors      = 0;
	int      items_fed   = 0;
	int      quiet_cycles = 0;
	bit      idling      = 1'b1;   // gap/stall bursts enabled
	int      stall_left  = 0;

	// One hash through the search. Updates the shadow state and gives the
	// result the detector has to report for this transfer.
	function automatic void track_period(input logic [HASH_W-1:0] h, input logic st,
	                                     output report_t r);
		r.stat = ST_SEARCH;
		r.per  = '0;
		if (st) begin
			stk_depth = 0;
			step_no   = STEP_FIRST;
			run_done  = 1'b0;
		end
		if (run_done) begin
			r.stat = ST_IGNORED;
			return;
		end
		// keep hashes strictly increasing toward the top
		while (stk_depth > 0 && stk_hash[stk_depth-1] > h)
			stk_depth--;
		if (stk_depth > 0 && stk_hash[stk_depth-1] == h) begin
			r.stat   = ST_FOUND;
			r.per    = step_no - stk_idx[stk_depth-1];
			run_done = 1'b1;
		end else begin
			// a full stack drops the push, the rest goes on as usual
			if (stk_depth < STACK_DEPTH) begin
				stk_hash[stk_depth] = h;
				stk_idx[stk_depth]  = step_no;
				stk_depth++;
			end
			// a zero limit behaves like one: step 1 already reaches it
			if (step_no >= step_limit) begin
				r.stat   = ST_GAVEUP;
				run_done = 1'b1;
			end else begin
				step_no = step_no + 1'b1;
			end
		end
	endfunction

	// mostly full-width random hashes, some near zero or all-ones so that
	// collisions and the field extremes come up often
	function automatic logic [HASH_W-1:0] rand_hash();
		case ($urandom_range(0, 7))
			0: begin
				return HASH_W'($urandom_range(0, 15));
			end
			1: begin
				return ~HASH_W'($urandom_range(0, 15));
			end
			default: begin
				return {$urandom, $urandom};
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------------

	// One transfer. in_valid stays high on return so a following call can
	// keep the channel busy back to back; stop_feed drops it.
	task automatic send_item(input logic [HASH_W-1:0] h, input logic st);
		report_t r;
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		hash_value <= h;
		start_req  <= st;
		// values read right at the edge are the ones the block sampled
		@(posedge clk);
		while (in_stall) @(posedge clk);
		track_period(h, st, r);
		period_reports.push_back(r);
		items_fed++;
	endtask

	// stop feeding and wait until every expected result has come back
	task automatic stop_feed();
		in_valid <= 1'b0;
		while (period_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// max_steps is only written with the detector drained
	task automatic set_step_limit(input logic [IDX_W-1:0] v);
		stop_feed();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		step_limit  = v;
	endtask

	// Well-formed sequence: a short lead-in, then a cycle repeated until the
	// detector finishes. A cut run raises start somewhere in the middle.
	// A few stray hashes after the finish must come back ignored.
	task automatic feed_periodic_run(input bit cut_run);
		logic [HASH_W-1:0] seq [48];
		int lead;
		int span;
		int cut;
		int pos;
		int k;
		lead = $urandom_range(0, 8);
		span = $urandom_range(1, 40);
		for (k = 0; k < lead + span; k++)
			seq[k] = rand_hash();
		cut = cut_run ? $urandom_range(1, lead + span) : -1;
		k   = 0;
		send_item(seq[0], 1'b1);
		while (!run_done) begin
			k++;
			pos = (k < lead + span) ? k : lead + (k - lead) % span;
			send_item(seq[pos], k == cut);
		end
		repeat ($urandom_range(0, 2)) send_item(rand_hash(), 1'b0);
	endtask

	// ------------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------------

	// receiver stall bursts of random length
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 11);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// every result transfer is checked against the oldest expectation
	always @(posedge clk) begin : check_result
		report_t want;
		if (out_valid && !out_stall) begin
			if (period_reports.size() == 0) begin
				$error("result with none expected: status %0d period %0d", status, period);
				errors++;
			end else begin
				want = period_reports.pop_front();
				if (status !== want.stat) begin
					$error("status: expected %0d, got %0d", want.stat, status);
					errors++;
				end
				if (period !== want.per) begin
					$error("period: expected %0d, got %0d", want.per, period);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles in a row without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// Reset limit of 999. First item with no start flag, hash extremes,
	// a repeat one step apart, ignored items after finish, then a restart
	// with pops and a period of three.
	task automatic test_first_repeat();
		send_item('0, 1'b0);
		send_item('1, 1'b0);
		send_item('1, 1'b0);           // period 1
		send_item(HASH_W'(5), 1'b0);   // ignored after finish
		send_item('1, 1'b0);           // still ignored
		send_item(HASH_W'(7), 1'b1);
		send_item(HASH_W'(2), 1'b0);   // pops 7
		send_item(HASH_W'(9), 1'b0);
		send_item(HASH_W'(7), 1'b0);   // pops 9
		send_item(HASH_W'(2), 1'b0);   // pops 7, matches 2: period 3
	endtask

	// Step limit at zero and one give up on the first hash; two allows a
	// match on the last step, or gives up there without one.
	task automatic test_step_limit();
		set_step_limit('0);
		send_item(HASH_W'(3), 1'b1);   // gave up
		send_item(HASH_W'(3), 1'b0);   // ignored
		set_step_limit(IDX_W'(1));
		send_item('0, 1'b1);           // gave up
		set_step_limit(IDX_W'(2));
		send_item(HASH_W'(4), 1'b1);
		send_item(HASH_W'(4), 1'b0);   // match on the last step
		send_item(HASH_W'(4), 1'b1);
		send_item(HASH_W'(6), 1'b0);   // gave up on the last step
		set_step_limit('1);
	endtask

	// Mostly periodic runs with random content; some cut by a restart, some
	// collision-heavy noise, and step limit changes between runs.
	task automatic test_random_runs();
		int goal;
		goal = items_fed + RANDOM_ITEMS;
		while (items_fed < goal) begin
			idling = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				7: begin
					repeat ($urandom_range(5, 20))
						send_item(HASH_W'($urandom_range(0, 7)), $urandom_range(0, 7) == 0);
				end
				8: begin
					feed_periodic_run(1'b1);
				end
				9: begin
					case ($urandom_range(0, 3))
						0: set_step_limit(IDX_W'($urandom_range(0, 6)));
						1: set_step_limit('1);
						default: set_step_limit(IDX_W'($urandom_range(40, 300)));
					endcase
				end
				default: begin
					feed_periodic_run(1'b0);
				end
			endcase
		end
	endtask

	// back-to-back transfers and no stalls to close the run
	task automatic test_flat_out();
		idling = 1'b0;
		set_step_limit(MAX_STEPS_RST);
		repeat (3) feed_periodic_run(1'b0);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_repeat();
		test_step_limit();
		test_random_runs();
		test_flat_out();

		stop_feed();
		repeat (20) @(posedge clk);
		if (period_reports.size() != 0) begin
			$error("%0d expected results never came", period_reports.size());
			errors++;
		end
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
